/* src/dqkd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqkd_pkg
// Shared types and constants for the keyed-delete deque: command and status
// codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package dqkd_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_KEY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd4;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DEL_KEY,
        OP_DEL_FRONT,
        OP_DEL_BACK,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

endpackage

/* src/dqkd_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqkd_cmd_if
// Command channel: a valid/ready handshake carrying mode and key.
// ----------------------------------------------------------------------------
interface dqkd_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [dqkd_pkg::MODE_W-1:0]      mode;
    logic signed [dqkd_pkg::KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

/* src/dqkd_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqkd_rsp_if
// Response channel: a valid/ready handshake carrying status, value and last.
// ----------------------------------------------------------------------------
interface dqkd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dqkd_pkg::STATUS_W-1:0]     status;
    logic signed [dqkd_pkg::KEY_W-1:0] value;
    logic                              last;

    modport source (output valid, output status, output value, output last, input ready);
    modport sink   (input valid, input status, input value, input last, output ready);
endinterface

/* src/dqkd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqkd_cell
// One slot of the list. It holds an entry and its valid flag, compares the
// entry with the broadcast key and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module dqkd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dqkd_pkg::cell_op_t  op,
    input  dqkd_pkg::key_t      match_key,
    input  dqkd_pkg::key_t      head_data,
    input  dqkd_pkg::key_t      left_data,
    input  logic                left_valid,
    input  dqkd_pkg::key_t      right_data,
    input  logic                right_valid,
    input  logic                found_in,
    output dqkd_pkg::key_t      data,
    output logic                valid,
    output logic                found_out
);
    import dqkd_pkg::*;

    key_t data_reg;
    key_t data_next;
    logic valid_reg;
    logic valid_next;

    // The first matching slot and every slot behind it close the gap.
    assign found_out = found_in | (valid_reg && (data_reg == match_key));

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (op)
            OP_INSERT:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            OP_DEL_FRONT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            OP_DEL_KEY:
            begin
                if (found_out)
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
            OP_DEL_BACK:
            begin
                valid_next = valid_reg & right_valid;
            end
            OP_ROTATE:
            begin
                // The back slot wraps round to take the front entry.
                data_next = right_valid ? right_data : head_data;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

/* src/deque_with_key_delete_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_key_delete_core
// Bounded list of signed 32-bit keys with insert at the front, delete by key,
// delete front, delete back and full readout.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, the front in cell zero. Insert,
// delete by key, delete front and delete back each give one status word, so
// such commands are taken every cycle while the response side keeps up. A
// readout of N entries gives its entry words one after another, front entry
// first, as the response side takes them: the row rotates one place per word
// through the front cell, and after N steps it stands as before. No command is
// taken until the final readout word has entered the output register.
// ----------------------------------------------------------------------------
module deque_with_key_delete_core #(
    parameter int CAPACITY = dqkd_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dqkd_cmd_if.sink    cmd,
    dqkd_rsp_if.source  rsp
);
    import dqkd_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    state_t state_reg;
    state_t state_next;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [OCC_W-1:0] cnt_reg;
    logic [OCC_W-1:0] cnt_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    key_t                out_value_reg;
    logic                out_last_reg;

    logic                load;
    logic [STATUS_W-1:0] load_status;
    key_t                load_value;
    logic                load_last;

    cell_op_t  cell_op;
    key_t      cell_data  [CAPACITY];
    logic      cell_valid [CAPACITY];
    logic      found      [CAPACITY+1];

    logic out_free;
    logic accept;
    logic full;
    logic empty;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = cell_valid[CAPACITY-1];
    assign empty     = !cell_valid[0];
    assign found[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            key_t l_data;
            logic l_valid;
            key_t r_data;
            logic r_valid;

            if (g == 0)
            begin : g_first
                assign l_data  = cmd.key;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid
                assign l_data  = cell_data[g-1];
                assign l_valid = cell_valid[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_data  = cell_data[g+1];
                assign r_valid = cell_valid[g+1];
            end

            dqkd_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .match_key   (cmd.key),
                .head_data   (cell_data[0]),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .found_in    (found[g]),
                .data        (cell_data[g]),
                .valid       (cell_valid[g]),
                .found_out   (found[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.mode == MODE_READ) && !empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (out_free && (cnt_reg == OCC_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_op     = OP_HOLD;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        load        = 1'b0;
        load_status = ST_DONE;
        load_value  = '0;
        load_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.mode) inside
                        MODE_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                load_status = ST_FULL;
                            end
                            else
                            begin
                                cell_op  = OP_INSERT;
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        MODE_DEL_KEY:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                load_status = ST_EMPTY;
                            end
                            else if (found[CAPACITY])
                            begin
                                cell_op  = OP_DEL_KEY;
                                occ_next = occ_reg - OCC_W'(1);
                            end
                            else
                            begin
                                load_status = ST_MISSING;
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK:
                        begin
                            load = 1'b1;
                            if (empty)
                            begin
                                load_status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_op  = (cmd.mode == MODE_DEL_FRONT) ? OP_DEL_FRONT
                                                                        : OP_DEL_BACK;
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        MODE_READ:
                        begin
                            if (empty)
                            begin
                                load        = 1'b1;
                                load_status = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = occ_reg;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_status = ST_ENTRY;
                    load_value  = cell_data[0];
                    load_last   = (cnt_reg == OCC_W'(1));
                    cell_op     = OP_ROTATE;
                    cnt_next    = cnt_reg - OCC_W'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= load_status;
            out_value_reg  <= load_value;
            out_last_reg   <= load_last;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.last   = out_last_reg;

endmodule

/* tb/deque_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the command and response channels of the keyed-delete deque. It
// keeps its own copy of the list, works out the response words that every
// accepted command must give, and compares each accepted response word field
// by field with the oldest word still awaited.
// ----------------------------------------------------------------------------
module deque_checker #(
    parameter int CAPACITY = dqkd_pkg::CAPACITY_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    dqkd_cmd_if   cmd,
    dqkd_rsp_if   rsp,
    output int    errors,
    output int    outstanding,
    output int    words_checked,
    output int    full_drops
);
    import dqkd_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        key_t                value;
        logic                last;
    } rsp_word_t;

    key_t      list_keys [CAPACITY];
    int        list_len;
    rsp_word_t awaited_words [$];

    function automatic void await_word(input logic [STATUS_W-1:0] status, input key_t value,
                                       input logic last);
        rsp_word_t w;
        w.status = status;
        w.value  = value;
        w.last   = last;
        awaited_words = {awaited_words, w};
    endfunction

    function automatic void drop_entry(input int pos);
        for (int i = pos; i < list_len - 1; i++)
        begin
            list_keys[i] = list_keys[i + 1];
        end
        list_len--;
    endfunction

    function automatic void apply_command(input logic [MODE_W-1:0] mode, input key_t key);
        int hit;
        hit = -1;
        case (mode)
            MODE_INSERT:
            begin
                if (list_len >= CAPACITY)
                begin
                    await_word(ST_FULL, '0, 1'b1);
                    full_drops++;
                end
                else
                begin
                    for (int i = list_len; i > 0; i--)
                    begin
                        list_keys[i] = list_keys[i - 1];
                    end
                    list_keys[0] = key;
                    list_len++;
                    await_word(ST_DONE, '0, 1'b1);
                end
            end
            MODE_DEL_KEY:
            begin
                if (list_len == 0)
                begin
                    await_word(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        if (hit < 0 && list_keys[i] == key)
                        begin
                            hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        await_word(ST_MISSING, '0, 1'b1);
                    end
                    else
                    begin
                        drop_entry(hit);
                        await_word(ST_DONE, '0, 1'b1);
                    end
                end
            end
            MODE_DEL_FRONT:
            begin
                if (list_len == 0)
                begin
                    await_word(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    drop_entry(0);
                    await_word(ST_DONE, '0, 1'b1);
                end
            end
            MODE_DEL_BACK:
            begin
                if (list_len == 0)
                begin
                    await_word(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    list_len--;
                    await_word(ST_DONE, '0, 1'b1);
                end
            end
            MODE_READ:
            begin
                if (list_len == 0)
                begin
                    await_word(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        await_word(ST_ENTRY, list_keys[i], i == list_len - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_word_t want;
        if (!rst_n)
        begin
            list_len      = 0;
            awaited_words.delete();
            errors        = 0;
            words_checked = 0;
            full_drops    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                words_checked++;
                if (awaited_words.size() == 0)
                begin
                    errors++;
                    $error("Response word with nothing awaited: status %0d value %0d last %0d",
                           rsp.status, rsp.value, rsp.last);
                end
                else
                begin
                    want = awaited_words[0];
                    awaited_words.delete(0);
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                    end
                    if (rsp.value !== want.value)
                    begin
                        errors++;
                        $error("value mismatch: expected %0d, actual %0d",
                               want.value, rsp.value);
                    end
                    if (rsp.last !== want.last)
                    begin
                        errors++;
                        $error("last mismatch: expected %0d, actual %0d", want.last, rsp.last);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                apply_command(cmd.mode, cmd.key);
            end
        end
        outstanding = awaited_words.size();
    end

endmodule

/* tb/tb_deque_with_key_delete_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_key_delete_core
// Drives commands into the keyed-delete deque and paces its response side:
// a directed opening over empty, extreme and duplicate cases, then a fill to
// capacity and random command mixes under three idle patterns, including one
// long response stall. A checker beside the block judges every word.
// ----------------------------------------------------------------------------
module tb_deque_with_key_delete_core;
    import dqkd_pkg::*;

    typedef logic [MODE_W-1:0] mode_t;

    localparam int    DEPTH             = CAPACITY_DEF;
    localparam int    HOLD_CYCLES       = 300;
    localparam int    QUIET_LIMIT       = 5000;
    localparam int    SETTLE_CYCLES     = 20;
    localparam mode_t MODE_UNUSED_FIRST = 3'd5;
    localparam mode_t MODE_UNUSED_LAST  = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_req = 1'b0;
    int   cmds_sent = 0;
    int   quiet_cycles = 0;
    int   errors;
    int   outstanding;
    int   words_checked;
    int   full_drops;

    dqkd_cmd_if cmd_ch ();
    dqkd_rsp_if rsp_ch ();

    deque_with_key_delete_core #(
        .CAPACITY (DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    deque_checker #(
        .CAPACITY (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .rsp           (rsp_ch),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .full_drops    (full_drops)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    function automatic key_t random_key();
        key_t k;
        if ($urandom_range(0, 99) < 60)
        begin
            case ($urandom_range(0, 7))
                0: k = -1;
                1: k = 0;
                2: k = 1;
                3: k = 2;
                4: k = 3;
                5: k = 100;
                6: k = 32'sh8000_0000;
                default: k = 32'sh7fff_ffff;
            endcase
        end
        else
        begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic send_cmd(input mode_t mode, input key_t key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= mode;
        cmd_ch.key   <= key;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        cmds_sent++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    task automatic send_random_cmd(inout int counted);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            send_cmd(MODE_INSERT, random_key());
        end
        else if (r < 55)
        begin
            send_cmd(MODE_DEL_KEY, random_key());
        end
        else if (r < 65)
        begin
            send_cmd(MODE_DEL_FRONT, random_key());
        end
        else if (r < 75)
        begin
            send_cmd(MODE_DEL_BACK, random_key());
        end
        else if (r < 88)
        begin
            send_cmd(MODE_READ, random_key());
        end
        else
        begin
            send_cmd(mode_t'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)), $urandom);
            counted--;
        end
        counted++;
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_items,
                             input bit fill, input bit squeeze);
        int sent;
        sent = 0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (fill)
        begin
            repeat (DEPTH + 2) send_cmd(MODE_INSERT, random_key());
            send_cmd(MODE_READ, random_key());
        end
        if (squeeze)
        begin
            hold_req = 1'b1;
            send_cmd(MODE_READ, random_key());
            repeat (8) send_cmd(MODE_INSERT, random_key());
        end
        while (sent < n_items)
        begin
            send_random_cmd(sent);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode  <= MODE_INSERT;
        cmd_ch.key   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(MODE_READ, random_key());
        send_cmd(MODE_DEL_KEY, 5);
        send_cmd(MODE_DEL_FRONT, random_key());
        send_cmd(MODE_DEL_BACK, random_key());
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
        begin
            send_cmd(mode_t'(m), $urandom);
        end
        send_cmd(MODE_INSERT, 32'sh8000_0000);
        send_cmd(MODE_INSERT, 32'sh7fff_ffff);
        send_cmd(MODE_INSERT, 0);
        send_cmd(MODE_INSERT, -1);
        send_cmd(MODE_INSERT, 0);
        send_cmd(MODE_READ, random_key());
        send_cmd(MODE_DEL_KEY, 42);
        send_cmd(MODE_DEL_KEY, 0);
        send_cmd(MODE_READ, random_key());
        send_cmd(MODE_DEL_FRONT, random_key());
        send_cmd(MODE_DEL_BACK, random_key());
        send_cmd(MODE_READ, random_key());
        send_cmd(MODE_DEL_KEY, 32'sh7fff_ffff);
        send_cmd(MODE_DEL_KEY, 0);
        send_cmd(MODE_READ, random_key());
        wait_drained();

        run_phase(35, 78, 20, 1'b1, 1'b0);
        run_phase(78, 35, 20, 1'b0, 1'b0);
        run_phase(0, 0, 15, 1'b0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Summary: %0d commands over empty, extreme, full-list and random cases.",
                 cmds_sent);
        $display("Summary: %0d response words checked, %0d inserts dropped on a full list.",
                 words_checked, full_drops);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
src/dqkd_pkg.sv
src/dqkd_cmd_if.sv
src/dqkd_rsp_if.sv
src/dqkd_cell.sv
src/deque_with_key_delete_core.sv
tb/deque_checker.sv
tb/tb_deque_with_key_delete_core.sv
